// ===== hdl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Register map, class codes, reset values and the structs passed between
// the configuration block, the trigger generator and the echo measurement.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Field widths
    localparam int DIST_BITS    = 12;
    localparam int TRIG_HI_BITS = 16;
    localparam int TRIG_LO_BITS = 24;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int OUT_TOTAL_BITS = 32;

    // Default parameter values
    localparam int ECHO_WIDTH_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF      = 32;

    // 0.034 cm/us as an exact fraction 34/1000
    localparam int CM_NUM = 34;
    localparam int CM_DEN = 1000;
    localparam int REM_BITS = $clog2(CM_DEN);
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // Register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NEAR_LOW  = 3'd0,
        REG_NEAR_HIGH = 3'd1,
        REG_MID_HIGH  = 3'd2,
        REG_FAR_HIGH  = 3'd3,
        REG_TRIG_HIGH = 3'd4,
        REG_TRIG_LOW  = 3'd5
    } t_reg_idx;

    // Range classes
    typedef enum logic [1:0] {
        CLASS_NEAR = 2'd0,
        CLASS_MID  = 2'd1,
        CLASS_FAR  = 2'd2,
        CLASS_OUT  = 2'd3
    } t_class;

    // Register reset values
    localparam logic [DIST_BITS-1:0]    RST_NEAR_LOW  = 12'd2;
    localparam logic [DIST_BITS-1:0]    RST_NEAR_HIGH = 12'd50;
    localparam logic [DIST_BITS-1:0]    RST_MID_HIGH  = 12'd200;
    localparam logic [DIST_BITS-1:0]    RST_FAR_HIGH  = 12'd400;
    localparam logic [TRIG_HI_BITS-1:0] RST_TRIG_HIGH = 16'd10;
    localparam logic [TRIG_LO_BITS-1:0] RST_TRIG_LOW  = 24'd1000000;

    typedef struct packed {
        logic [DIST_BITS-1:0]    near_low;
        logic [DIST_BITS-1:0]    near_high;
        logic [DIST_BITS-1:0]    mid_high;
        logic [DIST_BITS-1:0]    far_high;
        logic [TRIG_HI_BITS-1:0] trig_high;
        logic [TRIG_LO_BITS-1:0] trig_low;
    } t_cfg;

    // Held measurement status
    typedef struct packed {
        logic                 done;
        logic [DIST_BITS-1:0] distance;
        t_class               range_class;
        logic                 in_range;
    } t_meas;

endpackage

// ===== hdl/uer_cfg.sv =====
// ----------------------------------------------------------------------------
// uer_cfg: configuration registers
// Holds the class thresholds and trigger phase lengths; unknown indexes
// are ignored.
// ----------------------------------------------------------------------------
module uer_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output uer_pkg::t_cfg                       o_cfg
);

    uer_pkg::t_cfg r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_low  <= uer_pkg::RST_NEAR_LOW;
            r_cfg.near_high <= uer_pkg::RST_NEAR_HIGH;
            r_cfg.mid_high  <= uer_pkg::RST_MID_HIGH;
            r_cfg.far_high  <= uer_pkg::RST_FAR_HIGH;
            r_cfg.trig_high <= uer_pkg::RST_TRIG_HIGH;
            r_cfg.trig_low  <= uer_pkg::RST_TRIG_LOW;
        end else if (i_cfg_we) begin
            unique case (uer_pkg::t_reg_idx'(i_cfg_index))
                uer_pkg::REG_NEAR_LOW: begin
                    r_cfg.near_low <= i_cfg_data[uer_pkg::DIST_BITS-1:0];
                end
                uer_pkg::REG_NEAR_HIGH: begin
                    r_cfg.near_high <= i_cfg_data[uer_pkg::DIST_BITS-1:0];
                end
                uer_pkg::REG_MID_HIGH: begin
                    r_cfg.mid_high <= i_cfg_data[uer_pkg::DIST_BITS-1:0];
                end
                uer_pkg::REG_FAR_HIGH: begin
                    r_cfg.far_high <= i_cfg_data[uer_pkg::DIST_BITS-1:0];
                end
                uer_pkg::REG_TRIG_HIGH: begin
                    r_cfg.trig_high <= i_cfg_data[uer_pkg::TRIG_HI_BITS-1:0];
                end
                uer_pkg::REG_TRIG_LOW: begin
                    r_cfg.trig_low <= i_cfg_data[uer_pkg::TRIG_LO_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/uer_trigger.sv =====
// ----------------------------------------------------------------------------
// uer_trigger: trigger pulse generator
// Counts ticks in the current phase and toggles between the high and low
// phase when the configured length is reached. A length of zero acts as one.
// ----------------------------------------------------------------------------
module uer_trigger (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  uer_pkg::t_cfg i_cfg,
    output logic          o_trigger_level
);

    logic                               r_phase_high;
    logic [uer_pkg::TRIG_LO_BITS-1:0]   r_phase_ticks;
    logic [uer_pkg::TRIG_LO_BITS-1:0]   n_phase_ticks;
    logic [uer_pkg::TRIG_LO_BITS-1:0]   len_raw;
    logic [uer_pkg::TRIG_LO_BITS-1:0]   len;

    // Pick the length of the current phase, clamping zero to one
    always_comb begin
        len_raw = r_phase_high ? uer_pkg::TRIG_LO_BITS'(i_cfg.trig_high)
                               : i_cfg.trig_low;
        len = (len_raw == '0) ? uer_pkg::TRIG_LO_BITS'(1) : len_raw;
        n_phase_ticks = r_phase_ticks + uer_pkg::TRIG_LO_BITS'(1);
    end

    // Advance the phase counter once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_high  <= 1'b1;
            r_phase_ticks <= '0;
        end else if (i_adv) begin
            if (n_phase_ticks >= len) begin
                r_phase_high  <= ~r_phase_high;
                r_phase_ticks <= '0;
            end else begin
                r_phase_ticks <= n_phase_ticks;
            end
        end
    end

    // Drive of this tick is the phase before the update
    assign o_trigger_level = r_phase_high;

endmodule

// ===== hdl/uer_echo.sv =====
// ----------------------------------------------------------------------------
// uer_echo: echo width measurement and range classification
// Tracks floor(width*34/1000) incrementally as a quotient and remainder while
// echo is high, so no multiply or divide is needed. On the falling edge it
// latches the distance, classifies it and bumps the near, mid or far counter.
// ----------------------------------------------------------------------------
module uer_echo #(
    parameter int ECHO_WIDTH_BITS = uer_pkg::ECHO_WIDTH_BITS_DEF,
    parameter int COUNT_BITS      = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_echo,
    input  uer_pkg::t_cfg          i_cfg,
    output uer_pkg::t_meas         o_meas,
    output logic [COUNT_BITS-1:0]  o_near_total,
    output logic [COUNT_BITS-1:0]  o_mid_total,
    output logic [COUNT_BITS-1:0]  o_far_total
);

    localparam int REM_BITS  = uer_pkg::REM_BITS;
    localparam int DIST_BITS = uer_pkg::DIST_BITS;

    logic                       r_echo_prev;
    logic [ECHO_WIDTH_BITS-1:0] r_width;
    logic [REM_BITS-1:0]        r_rem;
    logic [DIST_BITS-1:0]       r_quot;
    logic [DIST_BITS-1:0]       r_distance;
    uer_pkg::t_class            r_class;
    logic                       r_in_range;
    logic [COUNT_BITS-1:0]      r_near_cnt;
    logic [COUNT_BITS-1:0]      r_mid_cnt;
    logic [COUNT_BITS-1:0]      r_far_cnt;

    logic [REM_BITS:0]          rem_sum;
    logic [REM_BITS-1:0]        n_rem;
    logic [DIST_BITS-1:0]       n_quot;
    uer_pkg::t_class            n_class;
    logic                       fall;

    // Add 34 to the remainder, carry into the saturating quotient
    always_comb begin
        rem_sum = (REM_BITS+1)'(r_rem) + (REM_BITS+1)'(uer_pkg::CM_NUM);
        if (rem_sum >= (REM_BITS+1)'(uer_pkg::CM_DEN)) begin
            n_rem  = REM_BITS'(rem_sum - (REM_BITS+1)'(uer_pkg::CM_DEN));
            n_quot = (r_quot == uer_pkg::DIST_MAX) ? r_quot
                                                   : r_quot + DIST_BITS'(1);
        end else begin
            n_rem  = REM_BITS'(rem_sum);
            n_quot = r_quot;
        end
    end

    // Classify the finished distance; first matching class wins
    always_comb begin
        if (r_quot >= i_cfg.near_low && r_quot <= i_cfg.near_high) begin
            n_class = uer_pkg::CLASS_NEAR;
        end else if (r_quot > i_cfg.near_high && r_quot <= i_cfg.mid_high) begin
            n_class = uer_pkg::CLASS_MID;
        end else if (r_quot > i_cfg.mid_high && r_quot <= i_cfg.far_high) begin
            n_class = uer_pkg::CLASS_FAR;
        end else begin
            n_class = uer_pkg::CLASS_OUT;
        end
    end

    assign fall = ~i_echo & r_echo_prev;

    // Update width tracking and held results once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_prev <= 1'b0;
            r_width     <= '0;
            r_rem       <= '0;
            r_quot      <= '0;
            r_distance  <= '0;
            r_class     <= uer_pkg::CLASS_OUT;
            r_in_range  <= 1'b0;
            r_near_cnt  <= '0;
            r_mid_cnt   <= '0;
            r_far_cnt   <= '0;
        end else if (i_adv) begin
            r_echo_prev <= i_echo;
            if (i_echo) begin
                if (r_width != '1) begin
                    r_width <= r_width + ECHO_WIDTH_BITS'(1);
                    r_rem   <= n_rem;
                    r_quot  <= n_quot;
                end
            end else if (r_echo_prev) begin
                r_distance <= r_quot;
                r_class    <= n_class;
                r_in_range <= (n_class != uer_pkg::CLASS_OUT);
                r_width    <= '0;
                r_rem      <= '0;
                r_quot     <= '0;
                unique case (n_class)
                    uer_pkg::CLASS_NEAR: r_near_cnt <= r_near_cnt + COUNT_BITS'(1);
                    uer_pkg::CLASS_MID:  r_mid_cnt  <= r_mid_cnt + COUNT_BITS'(1);
                    uer_pkg::CLASS_FAR:  r_far_cnt  <= r_far_cnt + COUNT_BITS'(1);
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_meas.done        = fall;
    assign o_meas.distance    = r_distance;
    assign o_meas.range_class = r_class;
    assign o_meas.in_range    = r_in_range;
    assign o_near_total       = r_near_cnt;
    assign o_mid_total        = r_mid_cnt;
    assign o_far_total        = r_far_cnt;

endmodule

// ===== hdl/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: ultrasonic ranging sensor controller
// Takes one echo pin sample per microsecond tick and returns one result per
// tick: trigger drive, measurement strobe, last distance, class and totals.
// ----------------------------------------------------------------------------
// The block takes one tick per clock cycle while its input is not stalled and
// returns its result through the input register and then the result
// register. The distance is built up tick by tick as a quotient and remainder
// of width*34/1000 while echo is high, so each tick needs only one small add
// and compare; the falling edge then latches and classifies it in that cycle.
// After reset the trigger starts its high phase and no distance is held
// (class is out of range). Input stall rises only when both stages are full
// and the result side stalls.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
    parameter int ECHO_WIDTH_BITS = uer_pkg::ECHO_WIDTH_BITS_DEF,
    parameter int COUNT_BITS      = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration
    input  logic                                 i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // Tick input
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_echo_level,
    // Result output
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_trigger_level,
    output logic                                 o_measure_done,
    output logic [uer_pkg::DIST_BITS-1:0]        o_distance_cm,
    output logic [1:0]                           o_range_class,
    output logic                                 o_in_range,
    output logic [uer_pkg::OUT_TOTAL_BITS-1:0]   o_near_total,
    output logic [uer_pkg::OUT_TOTAL_BITS-1:0]   o_mid_total,
    output logic [uer_pkg::OUT_TOTAL_BITS-1:0]   o_far_total
);

    uer_pkg::t_cfg          cfg;
    uer_pkg::t_meas         meas;
    logic                   trig_now;
    logic [COUNT_BITS-1:0]  near_cnt;
    logic [COUNT_BITS-1:0]  mid_cnt;
    logic [COUNT_BITS-1:0]  far_cnt;

    logic   r_in_valid;
    logic   r_in_echo;
    logic   r_out_valid;
    logic   r_out_trigger;
    logic   r_out_done;
    logic   adv;
    logic   in_take;

    // Move the held tick into the result register when it is free or taken
    assign adv        = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & r_out_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;

    uer_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    uer_trigger u_trigger (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_cfg           (cfg),
        .o_trigger_level (trig_now)
    );

    uer_echo #(
        .ECHO_WIDTH_BITS (ECHO_WIDTH_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_echo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_echo       (r_in_echo),
        .i_cfg        (cfg),
        .o_meas       (meas),
        .o_near_total (near_cnt),
        .o_mid_total  (mid_cnt),
        .o_far_total  (far_cnt)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_echo <= i_echo_level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_trigger <= trig_now;
            r_out_done    <= meas.done;
        end
    end

    // Held results update only together with the result register
    assign o_out_valid     = r_out_valid;
    assign o_trigger_level = r_out_trigger;
    assign o_measure_done  = r_out_done;
    assign o_distance_cm   = meas.distance;
    assign o_range_class   = meas.range_class;
    assign o_in_range      = meas.in_range;
    assign o_near_total    = uer_pkg::OUT_TOTAL_BITS'(near_cnt);
    assign o_mid_total     = uer_pkg::OUT_TOTAL_BITS'(mid_cnt);
    assign o_far_total     = uer_pkg::OUT_TOTAL_BITS'(far_cnt);

endmodule

// ===== hdl/uer_checker.sv =====
// ----------------------------------------------------------------------------
// uer_checker: port-level checks of the echo ranger
// Watches the handshakes and the held results over time.
// ----------------------------------------------------------------------------
module uer_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_in_stall,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 o_measure_done,
    input  logic [uer_pkg::DIST_BITS-1:0]        o_distance_cm,
    input  logic [1:0]                           o_range_class,
    input  logic                                 o_in_range,
    input  logic [uer_pkg::OUT_TOTAL_BITS-1:0]   o_near_total
);

    // Result register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Input stalls only when the result side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stall without a full, stalled result");

    // In-range flag agrees with the class
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_range == (o_range_class != uer_pkg::CLASS_OUT))
        else $error("in_range disagrees with class");

    // Near total moves only with a shown near measurement
    a_near_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_near_total) |->
            (o_out_valid && o_measure_done && o_range_class == uer_pkg::CLASS_NEAR))
        else $error("near total changed without a near measurement");

    // Stalled result holds its distance
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_distance_cm)))
        else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_measure_done (o_measure_done),
    .o_distance_cm  (o_distance_cm),
    .o_range_class  (o_range_class),
    .o_in_range     (o_in_range),
    .o_near_total   (o_near_total)
);

// ===== bench/ultrasonic_echo_ranger_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb: self-checking bench for the echo ranger
// Streams echo samples, one per transfer, with random gaps on the input side
// and random stalls on the result side. A local model of the trigger timer,
// echo width counter, distance scaling and classifier predicts every per-tick
// result, and each result is compared field by field. Thresholds and trigger
// lengths are rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;

    localparam int CLK_PERIOD  = 20;
    localparam int ECHO_BITS   = uer_pkg::ECHO_WIDTH_BITS_DEF;
    localparam int RAND_PHASES = 3;
    // Indexes outside the register map, written to check they are ignored
    localparam logic [uer_pkg::CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [uer_pkg::CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} t_idle_mode;

    typedef struct packed {
        logic                               trigger;
        logic                               done;
        logic [uer_pkg::DIST_BITS-1:0]      distance;
        uer_pkg::t_class                    cls;
        logic                               in_range;
        logic [uer_pkg::OUT_TOTAL_BITS-1:0] near_n;
        logic [uer_pkg::OUT_TOTAL_BITS-1:0] mid_n;
        logic [uer_pkg::OUT_TOTAL_BITS-1:0] far_n;
    } t_tick_result;

    // DUT connections
    logic                               i_clk        = 1'b0;
    logic                               i_rst_n      = 1'b0;
    logic                               i_cfg_we     = 1'b0;
    logic [uer_pkg::CFG_IDX_BITS-1:0]   i_cfg_index  = '0;
    logic [uer_pkg::CFG_DATA_BITS-1:0]  i_cfg_data   = '0;
    logic                               i_in_valid   = 1'b0;
    logic                               i_echo_level = 1'b0;
    logic                               i_out_stall  = 1'b0;
    logic                               o_in_stall;
    logic                               o_out_valid;
    logic                               o_trigger_level;
    logic                               o_measure_done;
    logic [uer_pkg::DIST_BITS-1:0]      o_distance_cm;
    logic [1:0]                         o_range_class;
    logic                               o_in_range;
    logic [uer_pkg::OUT_TOTAL_BITS-1:0] o_near_total;
    logic [uer_pkg::OUT_TOTAL_BITS-1:0] o_mid_total;
    logic [uer_pkg::OUT_TOTAL_BITS-1:0] o_far_total;

    // Ranger model state and its copy of the registers
    uer_pkg::t_cfg                      ranger_cfg;
    logic                               trig_phase_high;
    logic [uer_pkg::TRIG_LO_BITS-1:0]   phase_count;
    logic                               echo_prev;
    logic [ECHO_BITS-1:0]               echo_width;
    logic [uer_pkg::DIST_BITS-1:0]      held_distance;
    uer_pkg::t_class                    held_class;
    logic                               held_in_range;
    logic [uer_pkg::OUT_TOTAL_BITS-1:0] near_count;
    logic [uer_pkg::OUT_TOTAL_BITS-1:0] mid_count;
    logic [uer_pkg::OUT_TOTAL_BITS-1:0] far_count;
    int unsigned                        out_count;
    int unsigned                        measures_seen;

    // Stimulus and scoreboard
    logic          echo_samples[$];
    t_tick_result  expected_results[$];
    logic          queued_prev   = 1'b0;
    int unsigned   ticks_queued  = 0;
    int unsigned   edges_queued  = 0;
    int unsigned   ticks_checked = 0;
    int unsigned   writes_done   = 0;
    int unsigned   mismatches    = 0;
    int unsigned   gap_left      = 0;
    int unsigned   stall_left    = 0;
    t_idle_mode    idle_mode     = IDLE_FULL;

    ultrasonic_echo_ranger u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_echo_level    (i_echo_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_trigger_level (o_trigger_level),
        .o_measure_done  (o_measure_done),
        .o_distance_cm   (o_distance_cm),
        .o_range_class   (o_range_class),
        .o_in_range      (o_in_range),
        .o_near_total    (o_near_total),
        .o_mid_total     (o_mid_total),
        .o_far_total     (o_far_total)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Load the post-reset state of the ranger model
    function automatic void reset_ranger();
        ranger_cfg.near_low  = uer_pkg::RST_NEAR_LOW;
        ranger_cfg.near_high = uer_pkg::RST_NEAR_HIGH;
        ranger_cfg.mid_high  = uer_pkg::RST_MID_HIGH;
        ranger_cfg.far_high  = uer_pkg::RST_FAR_HIGH;
        ranger_cfg.trig_high = uer_pkg::RST_TRIG_HIGH;
        ranger_cfg.trig_low  = uer_pkg::RST_TRIG_LOW;
        trig_phase_high = 1'b1;
        phase_count     = '0;
        echo_prev       = 1'b0;
        echo_width      = '0;
        held_distance   = '0;
        held_class      = uer_pkg::CLASS_OUT;
        held_in_range   = 1'b0;
        near_count      = '0;
        mid_count       = '0;
        far_count       = '0;
        out_count       = 0;
        measures_seen   = 0;
    endfunction

    // Classes are tried in order near, mid, far; first hit wins
    function automatic void classify_distance(input logic [uer_pkg::DIST_BITS-1:0] d);
        held_in_range = 1'b1;
        if (d >= ranger_cfg.near_low && d <= ranger_cfg.near_high) begin
            held_class = uer_pkg::CLASS_NEAR;
            near_count = near_count + uer_pkg::OUT_TOTAL_BITS'(1);
        end else if (d > ranger_cfg.near_high && d <= ranger_cfg.mid_high) begin
            held_class = uer_pkg::CLASS_MID;
            mid_count  = mid_count + uer_pkg::OUT_TOTAL_BITS'(1);
        end else if (d > ranger_cfg.mid_high && d <= ranger_cfg.far_high) begin
            held_class = uer_pkg::CLASS_FAR;
            far_count  = far_count + uer_pkg::OUT_TOTAL_BITS'(1);
        end else begin
            held_class    = uer_pkg::CLASS_OUT;
            held_in_range = 1'b0;
            out_count++;
        end
    endfunction

    // Advance the model by one tick and return the result it should produce
    function automatic t_tick_result step_ranger(input logic echo);
        t_tick_result                     r;
        logic [uer_pkg::TRIG_LO_BITS-1:0] len;
        logic [31:0]                      scaled;
        r.trigger = trig_phase_high;
        r.done    = 1'b0;
        len = trig_phase_high ? uer_pkg::TRIG_LO_BITS'(ranger_cfg.trig_high)
                              : ranger_cfg.trig_low;
        if (len == '0)
            len = uer_pkg::TRIG_LO_BITS'(1);
        phase_count = phase_count + uer_pkg::TRIG_LO_BITS'(1);
        if (phase_count >= len) begin
            trig_phase_high = ~trig_phase_high;
            phase_count     = '0;
        end
        if (echo) begin
            if (echo_width != '1)
                echo_width = echo_width + ECHO_BITS'(1);
        end else if (echo_prev) begin
            scaled = 32'(echo_width) * 32'(uer_pkg::CM_NUM) / 32'(uer_pkg::CM_DEN);
            held_distance = (scaled > 32'(uer_pkg::DIST_MAX))
                          ? uer_pkg::DIST_MAX : scaled[uer_pkg::DIST_BITS-1:0];
            classify_distance(held_distance);
            echo_width = '0;
            r.done     = 1'b1;
            measures_seen++;
        end
        echo_prev  = echo;
        r.distance = held_distance;
        r.cls      = held_class;
        r.in_range = held_in_range;
        r.near_n   = near_count;
        r.mid_n    = mid_count;
        r.far_n    = far_count;
        return r;
    endfunction

    // Gap or stall length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        case (idle_mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return (r < 20) ? 1 : 0;
            default: begin
                if (r < 70)
                    return 0;
                else if (r < 92)
                    return $urandom_range(1, 3);
                else if (r < 98)
                    return $urandom_range(4, 12);
                else
                    return $urandom_range(20, 60);
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Driver: predict on each transfer, then launch the next sample or idle
    always @(posedge i_clk) begin : feed_ticks
        logic launch;
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_echo_level <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(step_ranger(i_echo_level));
            if (!i_in_valid || !o_in_stall) begin
                launch = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (echo_samples.size() > 0) begin
                    launch = 1'b1;
                    i_echo_level <= echo_samples.pop_front();
                    gap_left = idle_len();
                end
                i_in_valid <= launch;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : watch_results
        t_tick_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $error("result transfer with no prediction pending");
                end else begin
                    want = expected_results.pop_front();
                    check_field("trigger_level", 32'(want.trigger), 32'(o_trigger_level));
                    check_field("measure_done",  32'(want.done),    32'(o_measure_done));
                    check_field("distance_cm",   32'(want.distance), 32'(o_distance_cm));
                    check_field("range_class",   32'(want.cls),     32'(o_range_class));
                    check_field("in_range",      32'(want.in_range), 32'(o_in_range));
                    check_field("near_total",    want.near_n,   o_near_total);
                    check_field("mid_total",     want.mid_n,    o_mid_total);
                    check_field("far_total",     want.far_n,    o_far_total);
                    ticks_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    task automatic queue_level(input logic lvl, input int unsigned n);
        repeat (n) begin
            if (queued_prev && !lvl)
                edges_queued++;
            echo_samples.push_back(lvl);
            queued_prev = lvl;
            ticks_queued++;
        end
    endtask

    task automatic queue_pulse(input int unsigned low_len, input int unsigned high_len);
        queue_level(1'b0, low_len);
        queue_level(1'b1, high_len);
    endtask

    // Hold off until every prediction is matched, then let the pipe empty
    task automatic settle();
        do
            @(negedge i_clk);
        while (echo_samples.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [uer_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            uer_pkg::REG_NEAR_LOW:  ranger_cfg.near_low  = val[uer_pkg::DIST_BITS-1:0];
            uer_pkg::REG_NEAR_HIGH: ranger_cfg.near_high = val[uer_pkg::DIST_BITS-1:0];
            uer_pkg::REG_MID_HIGH:  ranger_cfg.mid_high  = val[uer_pkg::DIST_BITS-1:0];
            uer_pkg::REG_FAR_HIGH:  ranger_cfg.far_high  = val[uer_pkg::DIST_BITS-1:0];
            uer_pkg::REG_TRIG_HIGH: ranger_cfg.trig_high = val[uer_pkg::TRIG_HI_BITS-1:0];
            uer_pkg::REG_TRIG_LOW:  ranger_cfg.trig_low  = val[uer_pkg::TRIG_LO_BITS-1:0];
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic write_thresholds(input int unsigned t0, input int unsigned t1,
                                    input int unsigned t2, input int unsigned t3);
        write_reg(uer_pkg::REG_NEAR_LOW,  uer_pkg::CFG_DATA_BITS'(t0));
        write_reg(uer_pkg::REG_NEAR_HIGH, uer_pkg::CFG_DATA_BITS'(t1));
        write_reg(uer_pkg::REG_MID_HIGH,  uer_pkg::CFG_DATA_BITS'(t2));
        write_reg(uer_pkg::REG_FAR_HIGH,  uer_pkg::CFG_DATA_BITS'(t3));
    endtask

    // Trigger phase length: zero, short, medium or the register maximum
    function automatic int unsigned pick_phase_len(input int unsigned top);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        else if (r == 1)
            return top;
        else if (r < 5)
            return $urandom_range(13, 300);
        else
            return $urandom_range(1, 12);
    endfunction

    // Mostly ordered small thresholds so short echoes reach every class
    task automatic randomize_config();
        int unsigned mode, t0, t1, t2, t3;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            t0 = $urandom_range(0, 2);
            t1 = t0 + $urandom_range(0, 3);
            t2 = t1 + $urandom_range(0, 4);
            t3 = t2 + $urandom_range(0, 6);
        end else if (mode < 9) begin
            t0 = $urandom_range(0, 12);
            t1 = $urandom_range(0, 12);
            t2 = $urandom_range(0, 12);
            t3 = $urandom_range(0, 12);
        end else begin
            t0 = $urandom_range(0, 4095);
            t1 = $urandom_range(0, 4095);
            t2 = $urandom_range(0, 4095);
            t3 = $urandom_range(0, 4095);
        end
        write_thresholds(t0, t1, t2, t3);
        write_reg(uer_pkg::REG_TRIG_HIGH,
                  uer_pkg::CFG_DATA_BITS'(pick_phase_len(32'h0000_FFFF)));
        write_reg(uer_pkg::REG_TRIG_LOW,
                  uer_pkg::CFG_DATA_BITS'(pick_phase_len(32'h00FF_FFFF)));
    endtask

    // One random stretch: echo pulses, pulses on a distance step, noise, quiet
    task automatic queue_random_burst();
        int unsigned kind, k, n;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            k = $urandom_range(0, 9);
            if (k < 6)
                n = $urandom_range(1, 40);
            else if (k < 9)
                n = $urandom_range(25, 120);
            else
                n = $urandom_range(120, 300);
            queue_pulse($urandom_range(1, 6), n);
        end else if (kind < 75) begin
            // width just around the step to the next whole centimeter
            k = $urandom_range(1, 6);
            n = (k * uer_pkg::CM_DEN + uer_pkg::CM_NUM - 1) / uer_pkg::CM_NUM
              + $urandom_range(0, 2) - 1;
            queue_pulse($urandom_range(1, 4), n);
        end else if (kind < 90) begin
            n = $urandom_range(4, 24);
            repeat (n) queue_level(1'($urandom_range(0, 1)), 1);
        end else begin
            queue_level(1'b0, $urandom_range(10, 120));
        end
    endtask

    initial begin : run_test
        int unsigned tick_mark, edge_mark;
        reset_ranger();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Echo already high out of reset, then a one-tick pulse, default setup
        queue_level(1'b1, 3);
        queue_level(1'b0, 2);
        queue_level(1'b1, 1);
        queue_level(1'b0, 1);
        settle();

        // Unmapped writes, zero trigger lengths, one-centimeter classes
        write_reg(REG_SPARE_6, 24'hFFFFFF);
        write_reg(REG_SPARE_7, 24'h000000);
        write_thresholds(0, 0, 1, 2);
        write_reg(uer_pkg::REG_TRIG_HIGH, '0);
        write_reg(uer_pkg::REG_TRIG_LOW,  '0);
        queue_pulse(2, 1);
        queue_pulse(2, 29);
        queue_pulse(2, 30);
        queue_pulse(2, 59);
        queue_pulse(2, 89);
        queue_level(1'b0, 2);
        settle();

        // Overlapping and inverted thresholds
        write_thresholds(4095, 0, 4095, 0);
        queue_pulse(2, 1);
        queue_pulse(2, 30);
        queue_level(1'b0, 2);
        settle();
        write_thresholds(5, 3, 2, 4);
        queue_pulse(2, 1);
        queue_pulse(2, 118);
        queue_pulse(2, 148);
        queue_level(1'b0, 2);
        settle();

        // Longer echoes under the longest trigger phases
        idle_mode = IDLE_LIGHT;
        write_thresholds(0, 4095, 4095, 4095);
        write_reg(uer_pkg::REG_TRIG_HIGH, 24'h00FFFF);
        write_reg(uer_pkg::REG_TRIG_LOW,  24'hFFFFFF);
        queue_pulse(3, 60);
        queue_pulse(3, 40);
        queue_level(1'b0, 3);
        settle();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_mode = (ph == 1) ? IDLE_NONE : IDLE_FULL;
            randomize_config();
            tick_mark = ticks_queued;
            edge_mark = edges_queued;
            while (ticks_queued - tick_mark < 100 || edges_queued - edge_mark < 2)
                queue_random_burst();
            queue_level(1'b0, 1);
            settle();
        end

        $display("Checked %0d ticks with %0d echo measurements:", ticks_checked,
                 measures_seen);
        $display("near %0d, mid %0d, far %0d, out %0d; %0d register writes, %0d random setups",
                 near_count, mid_count, far_count, out_count, writes_done, RAND_PHASES);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin : watchdog
        #(150_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/uer_pkg.sv
hdl/uer_cfg.sv
hdl/uer_trigger.sv
hdl/uer_echo.sv
hdl/ultrasonic_echo_ranger.sv
hdl/uer_checker.sv
bench/ultrasonic_echo_ranger_tb.sv
